// ===== design/esmrd_pkg.sv =====
// Shared types, constants and codes for the event signal map with retry dedup.
package esmrd_pkg;

   localparam int SLOTS = 256;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = SLOT_W + 1;

   localparam logic [1:0] KIND_INSTALL = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_SIGNAL = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_NO_INIT = 2'd3;

   localparam logic [7:0] NEVER_RETRY = 8'hFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] link_number;
      logic [31:0] frame_number;
      logic [7:0]  retry_count;
      logic [31:0] target_handle;
      logic [7:0]  signal_number;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       fire;
      logic [7:0] fired_signal;
      logic       suppressed;
      logic [7:0] slot_index;
   } rsp_type;

   typedef struct packed {
      logic [31:0] link;
      logic [31:0] handle;
      logic [7:0]  signal;
      logic [31:0] last_frame;
      logic [7:0]  last_retry;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSTALL,
      ST_LOOKUP,
      ST_RESP
   } state_type;

endpackage

// ===== design/esmrd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module esmrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/event_signal_map_with_retry_dedup.sv =====
// Top level of the event to signal map with late-retry suppression.
//
// The block keeps a table of SLOTS mappings from a (link number, target
// handle) pair to a host signal number, and handles one transaction at a
// time. An install scans the per-slot valid bits one slot per cycle for the
// lowest free slot. A remove or signal walks the slot memory one entry per
// cycle, comparing each entry in the cycle after its read; a transaction
// that finds its slot early finishes early. The scan through the slot
// memory, with its single read port, is what sets how long a transaction
// takes. A new request transaction is accepted as soon as the previous
// result has been moved into the output register, even if that result has
// not yet been taken downstream. Valid bits are flip-flops that reset
// clears immediately, so there is no clearing pass after reset.
module event_signal_map_with_retry_dedup (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  esmrd_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output esmrd_pkg::rsp_type rsp_payload
);

   import esmrd_pkg::*;

   // Control state.
   state_type        state_ff, state_in;
   logic             init_ff, init_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             chk_valid_ff, chk_valid_in;
   logic [SLOT_W-1:0] chk_idx_ff, chk_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload state.
   req_type          req_ff, req_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;

   // Slot memory port signals.
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   entry_type         wr_entry;
   logic [SLOT_W-1:0] rd_addr;
   entry_type         rd_entry;
   logic [ENTRY_W-1:0] rd_bits;

   logic [SLOT_W-1:0] scan_idx;
   logic              scan_done;
   logic              slot_free;
   logic              hit;
   logic              dup;
   logic              out_free;

   esmrd_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(ENTRY_W'(wr_entry)),
      .rd_addr(rd_addr),
      .rd_data(rd_bits)
   );

   assign rd_entry = entry_type'(rd_bits);

   // The scan counter is one bit wider than a slot index so that it can
   // reach SLOTS, which marks the end of the table.
   assign scan_idx  = cnt_ff[SLOT_W-1:0];
   assign scan_done = (cnt_ff == CNT_W'(SLOTS));
   assign slot_free = !valid_ff[scan_idx];

   // The entry read in the previous cycle is compared here; the valid bit
   // is checked at the same index because the memory itself carries none.
   assign hit = chk_valid_ff && valid_ff[chk_idx_ff] &&
                (rd_entry.link == req_ff.link_number) &&
                (rd_entry.handle == req_ff.target_handle);

   // A retry of a frame that has already fired carries the same frame
   // number but a different retry count; it is a late duplicate.
   assign dup = (rd_entry.last_frame == req_ff.frame_number) &&
                (rd_entry.last_retry != req_ff.retry_count);

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_payload.kind)
                  KIND_INSTALL: state_in = ST_INSTALL;
                  KIND_REMOVE, KIND_SIGNAL: state_in = init_ff ? ST_LOOKUP : ST_RESP;
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_INSTALL: begin
            if (scan_done || slot_free) begin
               state_in = ST_RESP;
            end
         end
         ST_LOOKUP: begin
            if (hit || (!chk_valid_ff && scan_done)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      init_in      = init_ff;
      valid_in     = valid_ff;
      cnt_in       = cnt_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = chk_idx_ff;
      wr_entry     = rd_entry;
      rd_addr      = scan_idx;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_payload;
               cnt_in = '0;
               res_in = '0;
               res_in.status = STATUS_OK;
               case (req_payload.kind)
                  KIND_INSTALL: begin
                     // The first install starts from an empty table.
                     if (!init_ff) begin
                        init_in  = 1'b1;
                        valid_in = '0;
                     end
                  end
                  KIND_REMOVE, KIND_SIGNAL: begin
                     if (!init_ff) begin
                        res_in.status = STATUS_NO_INIT;
                     end
                  end
                  default: begin
                     res_in.status = STATUS_OK;
                  end
               endcase
            end
         end
         ST_INSTALL: begin
            if (scan_done) begin
               res_in.status = STATUS_FULL;
            end else if (slot_free) begin
               valid_in[scan_idx]  = 1'b1;
               wr_en               = 1'b1;
               wr_addr             = scan_idx;
               wr_entry.link       = req_ff.link_number;
               wr_entry.handle     = req_ff.target_handle;
               wr_entry.signal     = req_ff.signal_number;
               wr_entry.last_frame = req_ff.frame_number - 32'd1;
               wr_entry.last_retry = NEVER_RETRY;
               res_in.status       = STATUS_OK;
               res_in.slot_index   = 8'(scan_idx);
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_LOOKUP: begin
            // Issue the next read while the previous one is compared.
            if (!scan_done) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = scan_idx;
               cnt_in       = cnt_ff + CNT_W'(1);
            end
            if (hit) begin
               chk_valid_in      = 1'b0;
               res_in.status     = STATUS_OK;
               res_in.slot_index = 8'(chk_idx_ff);
               if (req_ff.kind == KIND_REMOVE) begin
                  valid_in[chk_idx_ff] = 1'b0;
               end else if (dup) begin
                  res_in.suppressed = 1'b1;
               end else begin
                  res_in.fire         = 1'b1;
                  res_in.fired_signal = rd_entry.signal;
                  wr_en               = 1'b1;
                  wr_addr             = chk_idx_ff;
                  wr_entry.last_frame = req_ff.frame_number;
                  wr_entry.last_retry = req_ff.retry_count;
               end
            end else if (!chk_valid_ff && scan_done) begin
               res_in.status = STATUS_NOT_FOUND;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            chk_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         init_ff      <= 1'b0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_idx_ff <= chk_idx_in;
      req_ff     <= req_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== tb/event_signal_map_with_retry_dedup_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the event to signal map with late-retry suppression.
module event_signal_map_with_retry_dedup_tb;
   import esmrd_pkg::*;

   // The package names the three operations only. The fourth kind
   // encoding must leave the table alone and answer with an all-zero OK.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Run length and pacing. The directed tests send a little over five
   // hundred transactions, so the random phase brings the run to about two
   // thousand in all.
   localparam int RANDOM_ITEMS = 1450;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int RX_MODE_PERIOD = 400;

   // A remove or signal that misses walks the whole slot memory, so the
   // tail after the last expected response covers one full scan.
   localparam int DRAIN_TAIL = SLOTS + 8;

   // The limit sits well above the time that the slowest correct run takes.
   localparam int TIMEOUT_NS = 8000000;

   // These are the stall patterns of the response side. Each phase picks
   // one of them, and RX_MODE_PERIOD sets the length of a phase.
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_RANDOM,
      RX_PATTERN
   } rx_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // This mirror of the mapping table is updated in acceptance order. The
   // block handles one transaction at a time, so acceptance order is also
   // response order.
   bit        map_initialized;
   bit        map_valid      [SLOTS];
   bit [31:0] map_link       [SLOTS];
   bit [31:0] map_handle     [SLOTS];
   bit [7:0]  map_signal     [SLOTS];
   bit [31:0] map_last_frame [SLOTS];
   bit [7:0]  map_last_retry [SLOTS];

   // These are the responses still owed by the block, oldest first.
   rsp_type expected_rsp [$];
   rsp_type oldest_rsp;
   int      mismatch_count = 0;

   // Response-side pacing state. The stimulus may set hold_left to force
   // a long stretch of back pressure.
   int          hold_left = 0;
   int          rx_cycle = 0;
   rx_mode_type rx_mode = RX_OPEN;

   event_signal_map_with_retry_dedup dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor of the mapping table.
   // ------------------------------------------------------------------

   function automatic void clear_map();
      foreach (map_valid[i]) begin
         map_valid[i] = 1'b0;
         map_link[i] = '0;
         map_handle[i] = '0;
         map_signal[i] = '0;
         map_last_frame[i] = '0;
         map_last_retry[i] = '0;
      end
   endfunction

   // Install always takes the lowest free slot.
   function automatic int find_free_slot();
      for (int i = 0; i < SLOTS; i++)
         if (!map_valid[i])
            return i;
      return -1;
   endfunction

   // Remove and signal use the lowest valid slot that matches both the
   // link and the handle. A duplicate pair at a higher slot stays hidden
   // until the lower one is removed.
   function automatic int find_mapping(input logic [31:0] link, input logic [31:0] handle);
      for (int i = 0; i < SLOTS; i++)
         if (map_valid[i] && map_link[i] == link && map_handle[i] == handle)
            return i;
      return -1;
   endfunction

   // This applies one accepted transaction to the mirror and returns the
   // response that the block owes for it.
   function automatic rsp_type apply_to_map(input req_type r);
      rsp_type o;
      int      idx;
      o = '0;
      case (r.kind)
         KIND_INSTALL: begin
            // The first install ever also wipes the table.
            if (!map_initialized) begin
               clear_map();
               map_initialized = 1'b1;
            end
            idx = find_free_slot();
            if (idx < 0) begin
               o.status = STATUS_FULL;
            end else begin
               map_valid[idx] = 1'b1;
               map_link[idx] = r.link_number;
               map_handle[idx] = r.target_handle;
               map_signal[idx] = r.signal_number;
               // A signal in the install frame minus one is a retry of an
               // old frame unless it carries the never-seen retry count.
               map_last_frame[idx] = r.frame_number - 32'd1;
               map_last_retry[idx] = NEVER_RETRY;
               o.status = STATUS_OK;
               o.slot_index = idx[7:0];
            end
         end
         KIND_REMOVE, KIND_SIGNAL: begin
            if (!map_initialized) begin
               o.status = STATUS_NO_INIT;
            end else begin
               idx = find_mapping(r.link_number, r.target_handle);
               if (idx < 0) begin
                  o.status = STATUS_NOT_FOUND;
               end else begin
                  o.slot_index = idx[7:0];
                  if (r.kind == KIND_REMOVE) begin
                     map_valid[idx] = 1'b0;
                  end else if (map_last_frame[idx] == r.frame_number &&
                               map_last_retry[idx] != r.retry_count) begin
                     // Same frame with another retry count means a late
                     // duplicate. The slot keeps its history.
                     o.suppressed = 1'b1;
                  end else begin
                     o.fire = 1'b1;
                     o.fired_signal = map_signal[idx];
                     map_last_frame[idx] = r.frame_number;
                     map_last_retry[idx] = r.retry_count;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------

   function automatic req_type make_req(input logic [1:0] kind, input logic [31:0] link,
                                        input logic [31:0] frame, input logic [7:0] retry,
                                        input logic [31:0] handle, input logic [7:0] signo);
      req_type r;
      r.kind = kind;
      r.link_number = link;
      r.frame_number = frame;
      r.retry_count = retry;
      r.target_handle = handle;
      r.signal_number = signo;
      return r;
   endfunction

   // Half of the identifiers come from a tiny range. That makes duplicate
   // pairs and near misses (link matches, handle does not) common.
   function automatic logic [31:0] random_id();
      if ($urandom_range(1) == 0)
         return 32'($urandom_range(3));
      return $urandom();
   endfunction

   function automatic logic [31:0] random_frame();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // This returns a uniformly chosen valid slot of the mirror, or -1 when
   // the table is empty.
   function automatic int pick_mapped_slot();
      int count;
      int k;
      count = 0;
      foreach (map_valid[i])
         if (map_valid[i])
            count++;
      if (count == 0)
         return -1;
      k = $urandom_range(count - 1);
      foreach (map_valid[i]) begin
         if (map_valid[i]) begin
            if (k == 0)
               return i;
            k--;
         end
      end
      return -1;
   endfunction

   // Most removes and signals aim at existing mappings, and signal frames
   // are steered around the stored frame and retry. This exercises the
   // fire, refire and suppress paths. The rest is noise that misses.
   function automatic req_type make_random_request();
      req_type r;
      int      pick;
      int      slot;
      r = make_req(KIND_INSTALL, random_id(), random_frame(), 8'($urandom_range(255)),
                   random_id(), 8'($urandom_range(255)));
      pick = $urandom_range(99);
      if (pick < 24) begin
         r.kind = KIND_INSTALL;
      end else if (pick < 44) begin
         r.kind = KIND_REMOVE;
         slot = pick_mapped_slot();
         if (slot >= 0 && $urandom_range(3) != 0) begin
            r.link_number = map_link[slot];
            r.target_handle = map_handle[slot];
         end
      end else if (pick < 96) begin
         r.kind = KIND_SIGNAL;
         slot = pick_mapped_slot();
         if (slot >= 0 && $urandom_range(4) != 0) begin
            r.link_number = map_link[slot];
            r.target_handle = map_handle[slot];
            case ($urandom_range(5))
               0: begin
                  // This repeats the last fired frame and retry, so it fires again.
                  r.frame_number = map_last_frame[slot];
                  r.retry_count = map_last_retry[slot];
               end
               1: begin
                  // Same frame with a different retry is a late duplicate.
                  r.frame_number = map_last_frame[slot];
                  r.retry_count = map_last_retry[slot] ^ 8'($urandom_range(1, 255));
               end
               2: r.frame_number = map_last_frame[slot] + 32'd1;
               3: r.frame_number = map_last_frame[slot];
               default: ;
            endcase
         end
      end else begin
         r.kind = KIND_UNUSED;
      end
      return r;
   endfunction

   // This offers one transaction and waits for its acceptance. Valid is
   // left high, so that a following call keeps the channel busy with no gap.
   task automatic send_request(input req_type item);
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      expected_rsp.push_back(apply_to_map(item));
   endtask

   // This drops valid and leaves the request channel idle for a stretch set by its argument.
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1)
            @(negedge clock);
      end
   endtask

   // This stops offering and waits until every owed response has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Before any install, lookups report not initialized and the unused
   // kind answers with a clean OK.
   task automatic test_before_init();
      send_request(make_req(KIND_REMOVE, '0, '0, '0, '0, '0));
      send_request(make_req(KIND_SIGNAL, '1, '1, '1, '1, '1));
      send_request(make_req(KIND_UNUSED, '1, '1, '1, '1, '1));
      drain_results();
   endtask

   // These directed operations cover field extremes, the frame wrap on
   // install, fire, refire, suppression, duplicate pairs, lowest-slot
   // reuse and misses on a partial match.
   task automatic test_directed_ops();
      // The first install clears the table. Frame zero wraps the stored frame to all ones.
      send_request(make_req(KIND_INSTALL, '0, '0, '0, '0, '0));
      send_request(make_req(KIND_INSTALL, '1, '1, '1, '1, '1));
      // This is a retry of the wrapped frame with a fresh retry count, so it is dropped.
      send_request(make_req(KIND_SIGNAL, '0, '1, 8'd0, '0, '0));
      // The never-seen retry count with the wrapped frame fires.
      send_request(make_req(KIND_SIGNAL, '0, '1, NEVER_RETRY, '0, '0));
      send_request(make_req(KIND_SIGNAL, '0, '1, NEVER_RETRY, '0, '0));
      send_request(make_req(KIND_SIGNAL, '0, '1, 8'd1, '0, '0));
      send_request(make_req(KIND_SIGNAL, '0, '0, 8'd0, '0, '0));
      send_request(make_req(KIND_SIGNAL, '1, 32'hFFFF_FFFE, NEVER_RETRY, '1, '0));
      // A duplicate pair lands in slot two but stays shadowed by slot zero.
      send_request(make_req(KIND_INSTALL, '0, 32'h1234_5678, '0, '0, 8'h5A));
      send_request(make_req(KIND_SIGNAL, '0, 32'h0000_0010, 8'h33, '0, '0));
      send_request(make_req(KIND_REMOVE, '0, '0, '0, '0, '0));
      send_request(make_req(KIND_SIGNAL, '0, 32'h0000_0010, 8'h33, '0, '0));
      // A match on one of the two keys is still a miss.
      send_request(make_req(KIND_REMOVE, '0, '0, '0, '1, '0));
      send_request(make_req(KIND_SIGNAL, '1, '0, '0, '0, '0));
      // The freed slot zero is the lowest free slot again.
      send_request(make_req(KIND_INSTALL, 32'hA5A5_5A5A, 32'h8000_0000, '0,
                            32'h5A5A_A5A5, 8'h80));
      send_request(make_req(KIND_UNUSED, '1, '1, '1, '1, '1));
      send_request(make_req(KIND_REMOVE, 32'hA5A5_5A5A, '0, '0, 32'h5A5A_A5A5, '0));
      send_request(make_req(KIND_REMOVE, '1, '0, '0, '1, '0));
      send_request(make_req(KIND_REMOVE, '0, '0, '0, '0, '0));
      send_request(make_req(KIND_REMOVE, '0, '0, '0, '0, '0));
      drain_results();
   endtask

   // This fills every slot, proves that a further install reports a full
   // table, exercises the top slot, and then empties the table again.
   task automatic test_table_full();
      for (int n = 0; n < SLOTS; n++)
         send_request(make_req(KIND_INSTALL, $urandom(), random_frame(),
                               8'($urandom_range(255)), $urandom(),
                               8'($urandom_range(255))));
      send_request(make_req(KIND_INSTALL, '1, '1, '1, '1, '1));
      send_request(make_req(KIND_SIGNAL, map_link[SLOTS-1], map_last_frame[SLOTS-1] + 32'd1,
                            8'd0, map_handle[SLOTS-1], '0));
      send_request(make_req(KIND_REMOVE, map_link[SLOTS-1], '0, '0,
                            map_handle[SLOTS-1], '0));
      send_request(make_req(KIND_INSTALL, 32'h0BAD_F00D, '0, '0, 32'hF00D_0BAD, 8'h7F));
      // Walking upward, the slot under inspection is always the lowest
      // valid one, so its own pair removes exactly that slot.
      for (int idx = 0; idx < SLOTS; idx++)
         if (map_valid[idx])
            send_request(make_req(KIND_REMOVE, map_link[idx], '0, '0, map_handle[idx], '0));
      drain_results();
   endtask

   // The response side holds off for a long stretch while requests keep
   // coming. The block fills its output register and its work stage and
   // must then hold req_ready low without losing or reordering anything.
   task automatic test_backpressure();
      for (int n = 0; n < 4; n++)
         send_request(make_req(KIND_INSTALL, 32'(n), 32'(100 * n), '0, 32'(n + 16),
                               8'(n + 1)));
      drain_results();
      hold_left = HOLD_OFF_CYCLES;
      for (int n = 0; n < 12; n++)
         send_request(make_req((n % 5 == 4) ? KIND_REMOVE : KIND_SIGNAL, 32'(n % 4),
                               32'(100 * (n % 4) + n / 4), 8'(n), 32'(n % 4 + 16), '0));
      drain_results();
   endtask

   // This is random traffic in bursts with random gaps, with occasional
   // full drains and occasional forced response hold-offs.
   task automatic test_random();
      int burst_left;
      int gap;
      int pick;
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            pick = $urandom_range(99);
            if (pick < 40)
               gap = 0;
            else if (pick < 85)
               gap = $urandom_range(1, 6);
            else if (pick < 97)
               gap = $urandom_range(7, 40);
            else
               gap = $urandom_range(100, 300);
            pause_sender(gap);
            burst_left = $urandom_range(1, 24);
         end
         send_request(make_random_request());
         burst_left--;
         pick = $urandom_range(999);
         if (pick < 10) begin
            drain_results();
            burst_left = 0;
         end else if (pick < 13) begin
            hold_left = $urandom_range(100, 400);
         end
      end
      drain_results();
   endtask

   // ------------------------------------------------------------------
   // Response side: stall pattern and checking.
   // ------------------------------------------------------------------

   // rsp_ready changes at the falling edge only. A forced hold-off takes
   // precedence over the current stall pattern.
   always @(negedge clock) begin
      if (rx_cycle % RX_MODE_PERIOD == 0)
         rx_mode = rx_mode_type'($urandom_range(2));
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN: rsp_ready <= 1'b1;
            RX_RANDOM: rsp_ready <= ($urandom_range(9) > 2);
            default: rsp_ready <= ((rx_cycle % 8) > 2);
         endcase
      end
      rx_cycle++;
   end

   // Each accepted response is checked against the oldest owed one, field
   // by field. Case inequality also catches X or Z on the outputs.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $error("response with nothing outstanding: status %0d slot_index %0d",
                   rsp_payload.status, rsp_payload.slot_index);
            mismatch_count++;
         end else begin
            oldest_rsp = expected_rsp.pop_front();
            if (rsp_payload.status !== oldest_rsp.status) begin
               $error("status: expected %0d, actual %0d", oldest_rsp.status,
                      rsp_payload.status);
               mismatch_count++;
            end
            if (rsp_payload.fire !== oldest_rsp.fire) begin
               $error("fire: expected %0d, actual %0d", oldest_rsp.fire, rsp_payload.fire);
               mismatch_count++;
            end
            if (rsp_payload.fired_signal !== oldest_rsp.fired_signal) begin
               $error("fired_signal: expected %0d, actual %0d", oldest_rsp.fired_signal,
                      rsp_payload.fired_signal);
               mismatch_count++;
            end
            if (rsp_payload.suppressed !== oldest_rsp.suppressed) begin
               $error("suppressed: expected %0d, actual %0d", oldest_rsp.suppressed,
                      rsp_payload.suppressed);
               mismatch_count++;
            end
            if (rsp_payload.slot_index !== oldest_rsp.slot_index) begin
               $error("slot_index: expected %0d, actual %0d", oldest_rsp.slot_index,
                      rsp_payload.slot_index);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence of tests and end of run.
   // ------------------------------------------------------------------

   initial begin
      repeat (5)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_before_init();
      test_directed_ops();
      test_table_full();
      test_backpressure();
      test_random();

      // Any response beyond the owed ones would show up within one full
      // scan and would be flagged by the checker.
      drain_results();
      repeat (DRAIN_TAIL)
         @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule
